// ===== sv/lkt_pkg.sv =====
// Shared types, constants, microprogram and saturation helpers of the Kalman tracker.
package lkt_pkg;

  typedef logic signed [47:0] val_t;
  typedef logic [5:0] slot_t;

  localparam int unsigned NSLOT = 64;

  localparam logic [96:0] COV_MAX97 = 97'h7FFF_FFFF_FFFF;
  localparam logic [96:0] VAL_MAX97 = 97'h7FFF_FFFF;
  localparam val_t COV_MAX = 48'sh7FFF_FFFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_T   = 3'd0;
  localparam logic [2:0] REG_R   = 3'd1;
  localparam logic [2:0] REG_QX  = 3'd2;
  localparam logic [2:0] REG_QY  = 3'd3;
  localparam logic [2:0] REG_SP0 = 3'd4;
  localparam logic [2:0] REG_SV0 = 3'd5;
  localparam logic [2:0] REG_SP1 = 3'd6;
  localparam logic [2:0] REG_SV1 = 3'd7;

  typedef enum logic [3:0] {
    OP_END, OP_MUL, OP_ADD, OP_SUB, OP_MOV, OP_CLR, OP_MULG, OP_MULTT,
    OP_DIVW, OP_DIVOD, OP_DIVDD, OP_SING, OP_GO
  } op_e;

  typedef struct packed {
    op_e   op;
    logic  sat_val;
    slot_t a;
    slot_t b;
    slot_t d;
  } uop_t;

  // Register file slots; slots 0 to 9 are refilled at the start of every request.
  localparam slot_t S_T = 6'd0, S_R = 6'd1, S_QX = 6'd2, S_QY = 6'd3;
  localparam slot_t S_SP0 = 6'd4, S_SV0 = 6'd5, S_SP1 = 6'd6, S_SV1 = 6'd7;
  localparam slot_t S_MX = 6'd8, S_MY = 6'd9;
  localparam slot_t S_P0 = 6'd10, S_P1 = 6'd14;
  localparam slot_t S_W0 = 6'd18, S_W1 = 6'd20;
  localparam slot_t S_PS = 6'd22;
  localparam slot_t S_E = 6'd26;
  localparam slot_t S_NU0 = 6'd30, S_NU1 = 6'd31;
  localparam slot_t S_G = 6'd32, S_A0 = 6'd33, S_A1 = 6'd34, S_M00 = 6'd35;
  localparam slot_t S_M01 = 6'd36, S_X = 6'd37;
  localparam slot_t S_PB0 = 6'd38, S_PB1 = 6'd42;
  localparam slot_t S_S0 = 6'd46, S_S1 = 6'd47, S_T0 = 6'd48, S_T1 = 6'd49;
  localparam slot_t S_OD = 6'd50, S_DD = 6'd51;

  localparam logic [7:0] PC_COMMON = 8'd0;
  localparam logic [7:0] PC_INIT   = 8'd71;
  localparam logic [7:0] PC_UPD    = 8'd89;

  localparam logic C = 1'b0;
  localparam logic V = 1'b1;

  function automatic uop_t mk(op_e op, logic sv, slot_t a, slot_t b, slot_t d);
    uop_t u;
    u.op = op; u.sat_val = sv; u.a = a; u.b = b; u.d = d;
    return u;
  endfunction

  function automatic uop_t uc_rom(logic [7:0] pc);
    uop_t u;
    logic ax;
    logic [7:0] k;
    slot_t p, pb, w, s, qv;
    u = mk(OP_END, C, S_T, S_T, S_X);
    ax = 1'b0;
    k = 8'd0;
    if ((pc >= 8'd1 && pc <= 8'd38) || (pc >= 8'd40 && pc <= 8'd63)) begin
      if (pc <= 8'd38) begin
        ax = (pc >= 8'd20);
        k = ax ? pc - 8'd20 : pc - 8'd1;
      end else begin
        ax = (pc >= 8'd52);
        k = ax ? pc - 8'd52 : pc - 8'd40;
      end
    end
    p  = ax ? S_P1 : S_P0;
    pb = ax ? S_PB1 : S_PB0;
    w  = ax ? S_W1 : S_W0;
    s  = ax ? S_S1 : S_S0;
    qv = ax ? S_QY : S_QX;
    if (pc >= 8'd1 && pc <= 8'd38) begin
      // Covariance prediction F*P*F' + Q and innovation covariance of one axis
      case (k)
        8'd0:  u = mk(OP_MUL, C, S_G, qv, S_A0);
        8'd1:  u = mk(OP_MUL, C, S_T, qv, S_A1);
        8'd2:  u = mk(OP_MUL, C, S_T, p + 6'd2, S_X);
        8'd3:  u = mk(OP_ADD, C, p, S_X, S_M00);
        8'd4:  u = mk(OP_MUL, C, S_T, p + 6'd3, S_X);
        8'd5:  u = mk(OP_ADD, C, p + 6'd1, S_X, S_M01);
        8'd6:  u = mk(OP_MUL, C, S_M01, S_T, S_X);
        8'd7:  u = mk(OP_ADD, C, S_M00, S_X, pb);
        8'd8:  u = mk(OP_MUL, C, S_A0, S_G, S_X);
        8'd9:  u = mk(OP_ADD, C, pb, S_X, pb);
        8'd10: u = mk(OP_MUL, C, S_A0, S_T, S_X);
        8'd11: u = mk(OP_ADD, C, S_M01, S_X, pb + 6'd1);
        8'd12: u = mk(OP_MUL, C, p + 6'd3, S_T, S_X);
        8'd13: u = mk(OP_ADD, C, p + 6'd2, S_X, pb + 6'd2);
        8'd14: u = mk(OP_MUL, C, S_A1, S_G, S_X);
        8'd15: u = mk(OP_ADD, C, pb + 6'd2, S_X, pb + 6'd2);
        8'd16: u = mk(OP_MUL, C, S_A1, S_T, S_X);
        8'd17: u = mk(OP_ADD, C, p + 6'd3, S_X, pb + 6'd3);
        8'd18: u = mk(OP_ADD, C, pb, S_R, s);
        default: u = mk(OP_END, C, S_T, S_T, S_X);
      endcase
    end else if (pc >= 8'd40 && pc <= 8'd63) begin
      // Gain and covariance correction of one axis
      case (k)
        8'd0:  u = mk(OP_DIVW, V, pb, s, w);
        8'd1:  u = mk(OP_DIVW, V, pb + 6'd2, s, w + 6'd1);
        8'd2:  u = mk(OP_MUL, C, w, s, S_T0);
        8'd3:  u = mk(OP_MUL, C, w + 6'd1, s, S_T1);
        8'd4:  u = mk(OP_MUL, C, S_T0, w, S_X);
        8'd5:  u = mk(OP_SUB, C, pb, S_X, p);
        8'd6:  u = mk(OP_MUL, C, S_T0, w + 6'd1, S_X);
        8'd7:  u = mk(OP_SUB, C, pb + 6'd1, S_X, p + 6'd1);
        8'd8:  u = mk(OP_MUL, C, S_T1, w, S_X);
        8'd9:  u = mk(OP_SUB, C, pb + 6'd2, S_X, p + 6'd2);
        8'd10: u = mk(OP_MUL, C, S_T1, w + 6'd1, S_X);
        8'd11: u = mk(OP_SUB, C, pb + 6'd3, S_X, p + 6'd3);
        default: u = mk(OP_END, C, S_T, S_T, S_X);
      endcase
    end else begin
      case (pc)
        8'd0:  u = mk(OP_MULG, C, S_T, S_T, S_G);
        8'd39: u = mk(OP_SING, C, S_S0, S_S1, S_X);
        8'd64: u = mk(OP_MUL, V, S_T, S_E + 6'd1, S_X);
        8'd65: u = mk(OP_ADD, V, S_E, S_X, S_PS);
        8'd66: u = mk(OP_MOV, V, S_E + 6'd1, S_T, S_PS + 6'd1);
        8'd67: u = mk(OP_MUL, V, S_T, S_E + 6'd3, S_X);
        8'd68: u = mk(OP_ADD, V, S_E + 6'd2, S_X, S_PS + 6'd2);
        8'd69: u = mk(OP_MOV, V, S_E + 6'd3, S_T, S_PS + 6'd3);
        8'd70: u = mk(OP_END, C, S_T, S_T, S_X);
        8'd71: u = mk(OP_MOV, V, S_SP0, S_T, S_E);
        8'd72: u = mk(OP_MOV, V, S_SV0, S_T, S_E + 6'd1);
        8'd73: u = mk(OP_MOV, V, S_SP1, S_T, S_E + 6'd2);
        8'd74: u = mk(OP_MOV, V, S_SV1, S_T, S_E + 6'd3);
        8'd75: u = mk(OP_CLR, V, S_T, S_T, S_NU0);
        8'd76: u = mk(OP_CLR, V, S_T, S_T, S_NU1);
        8'd77: u = mk(OP_DIVOD, C, S_R, S_T, S_OD);
        8'd78: u = mk(OP_MULTT, C, S_T, S_T, S_X);
        8'd79: u = mk(OP_DIVDD, C, S_R, S_T, S_DD);
        8'd80: u = mk(OP_MOV, C, S_R, S_T, S_P0);
        8'd81: u = mk(OP_MOV, C, S_OD, S_T, S_P0 + 6'd1);
        8'd82: u = mk(OP_MOV, C, S_OD, S_T, S_P0 + 6'd2);
        8'd83: u = mk(OP_MOV, C, S_DD, S_T, S_P0 + 6'd3);
        8'd84: u = mk(OP_MOV, C, S_R, S_T, S_P1);
        8'd85: u = mk(OP_MOV, C, S_OD, S_T, S_P1 + 6'd1);
        8'd86: u = mk(OP_MOV, C, S_OD, S_T, S_P1 + 6'd2);
        8'd87: u = mk(OP_MOV, C, S_DD, S_T, S_P1 + 6'd3);
        8'd88: u = mk(OP_GO, C, S_T, S_T, S_X);
        8'd89: u = mk(OP_SUB, V, S_MX, S_PS, S_NU0);
        8'd90: u = mk(OP_SUB, V, S_MY, S_PS + 6'd2, S_NU1);
        8'd91: u = mk(OP_MUL, V, S_W0, S_NU0, S_X);
        8'd92: u = mk(OP_ADD, V, S_PS, S_X, S_E);
        8'd93: u = mk(OP_MUL, V, S_W0 + 6'd1, S_NU0, S_X);
        8'd94: u = mk(OP_ADD, V, S_PS + 6'd1, S_X, S_E + 6'd1);
        8'd95: u = mk(OP_MUL, V, S_W1, S_NU1, S_X);
        8'd96: u = mk(OP_ADD, V, S_PS + 6'd2, S_X, S_E + 6'd2);
        8'd97: u = mk(OP_MUL, V, S_W1 + 6'd1, S_NU1, S_X);
        8'd98: u = mk(OP_ADD, V, S_PS + 6'd3, S_X, S_E + 6'd3);
        8'd99: u = mk(OP_GO, C, S_T, S_T, S_X);
        default: u = mk(OP_END, C, S_T, S_T, S_X);
      endcase
    end
    return u;
  endfunction

  function automatic logic [47:0] mag48(val_t v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  // Applies a sign to a magnitude and saturates to the covariance or value range.
  function automatic val_t sat48(logic neg, logic [96:0] m, logic isval);
    logic [96:0] maxp;
    logic [47:0] r;
    maxp = isval ? VAL_MAX97 : COV_MAX97;
    if (neg) begin
      if (m > maxp + 97'd1) r = ~maxp[47:0];
      else r = 48'(-m[47:0]);
    end else begin
      r = (m > maxp) ? maxp[47:0] : m[47:0];
    end
    return val_t'(r);
  endfunction

  function automatic val_t sadd48(val_t a, val_t b, logic sub, logic isval);
    logic signed [48:0] s;
    logic signed [48:0] maxp;
    logic signed [48:0] r;
    s = sub ? (49'(a) - 49'(b)) : (49'(a) + 49'(b));
    maxp = isval ? 49'sh7FFF_FFFF : 49'sh7FFF_FFFF_FFFF;
    if (s > maxp) r = maxp;
    else if (s < -maxp - 49'sd1) r = -maxp - 49'sd1;
    else r = s;
    return val_t'(r[47:0]);
  endfunction

endpackage

// ===== sv/lkt_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module lkt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/lkt_mul.sv =====
// Iterative 48x48 unsigned multiplier built from four 24x24 partial products.
module lkt_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output logic        done_o,
  output logic [95:0] prod_o
);

  logic [47:0] a_q, b_q, pp_q;
  logic [95:0] acc_q;
  logic [1:0]  ppi_q;
  logic [2:0]  cnt_q;
  logic        pv_q, busy_q, done_q;
  logic [23:0] asel, bsel;
  logic [95:0] pp_sh;

  assign asel = cnt_q[1] ? a_q[47:24] : a_q[23:0];
  assign bsel = cnt_q[0] ? b_q[47:24] : b_q[23:0];

  always_comb begin
    case ({1'b0, ppi_q[1]} + {1'b0, ppi_q[0]})
      2'd0:    pp_sh = {48'd0, pp_q};
      2'd1:    pp_sh = {24'd0, pp_q, 24'd0};
      default: pp_sh = {pp_q, 48'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q != 3'd4) begin
          pv_q  <= 1'b1;
          cnt_q <= cnt_q + 3'd1;
        end else begin
          pv_q <= 1'b0;
          if (pv_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 96'd0;
    end else if (busy_q) begin
      pp_q  <= asel * bsel;
      ppi_q <= cnt_q[1:0];
      if (pv_q) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/lkt_div.sv =====
// Bit-serial restoring divider with round-half-up of the quotient.
module lkt_div #(
  parameter int unsigned NW = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [63:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, q_q;
  logic [63:0]   rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [64:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= 64'd0;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
      q_q   <= {q_q[NW-2:0], ge};
      num_q <= {num_q[NW-2:0], 1'b0};
    end
  end

  // The rounding bit is set when twice the remainder reaches the divisor.
  assign quot_o = q_q + NW'({rem_q, 1'b0} >= {1'b0, den_q});
  assign done_o = done_q;

endmodule

// ===== sv/linear_kalman_tracker.sv =====
// Two-axis constant-velocity Kalman tracker: configuration, microcode sequencer, datapath.
//
// Usage: configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle. A request on the slave stream carries the command in
// tuser (0 initialise from the start registers, 1 measurement update) and the
// measured position in tdata. Each request gives exactly one result on the master
// stream: the state estimate, the innovation and the predicted measurement in
// tdata, and the singular flag in tuser.
// The block works on one request at a time; s_axis_tready is high only when idle.
// Operands come from and results go to a small register file; products go
// through one shared multiplier and quotients through the bit-serial divider.
// After reset the register file is cleared, slot by slot, before the first
// request is taken. A finished result waits in the output register; the next
// request may be accepted meanwhile, and its result waits until that one is taken.
module linear_kalman_tracker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // meas_x, meas_y
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // est_pos_x, est_vel_x, est_pos_y, est_vel_y, innov_x, innov_y, pred_meas_x, pred_meas_y
  output logic [255:0] m_axis_tdata,
  output logic         m_axis_tuser   // singular_flag
);
  import lkt_pkg::*;

  localparam int unsigned DNW = 48 + 2 * FRAC_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [7:0]  pc_q, pc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] cfg_q [8];
  logic        cmd_q;
  logic [31:0] mx_q, my_q;
  logic [63:0] tt_q;
  logic        sing_q, sing_d;
  logic [31:0] est_q [4];
  logic [31:0] nu_q [2];
  logic [31:0] pm_q [2];
  logic [255:0] out_data_q;
  logic        out_user_q, out_valid_q;

  uop_t        u;
  val_t        rd_a, rd_b;
  logic [47:0] rd_a_raw, rd_b_raw;
  logic        we;
  slot_t       waddr;
  val_t        wdata;
  logic        mul_start, mul_done, div_start, div_done;
  logic [95:0] mul_prod;
  logic [DNW-1:0] div_num, div_quot;
  logic [63:0] div_den;
  logic        mul_neg, div_neg;
  logic [96:0] mul_rnd, mulg_rnd;
  val_t        mul_res, div_res, load_val, zero_div_val;
  logic        tt_we;
  logic        load_out;

  assign u    = uc_rom(pc_q);
  assign rd_a = val_t'(rd_a_raw);
  assign rd_b = val_t'(rd_b_raw);

  lkt_ram #(.WIDTH(48), .DEPTH(NSLOT)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (u.a),
    .raddr_b_i (u.b),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  lkt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag48(rd_a)),
    .b_i     (mag48(rd_b)),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    if (u.op == OP_DIVDD) begin
      div_num = DNW'({rd_a[47:0], 1'b0}) << (2 * FRAC_BITS);
      div_den = tt_q;
      div_neg = 1'b0;
    end else begin
      div_num = DNW'(mag48(rd_a)) << FRAC_BITS;
      div_den = 64'(mag48(rd_b));
      div_neg = rd_a[47] ^ rd_b[47];
    end
  end

  lkt_div #(.NW(DNW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mul_neg  = rd_a[47] ^ rd_b[47];
  assign mul_rnd  = ({1'b0, mul_prod} + (97'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign mulg_rnd = ({1'b0, mul_prod} + (97'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
  assign mul_res  = (u.op == OP_MULG) ? sat48(1'b0, mulg_rnd, 1'b0)
                                      : sat48(mul_neg, mul_rnd, u.sat_val);
  assign div_res  = sat48(div_neg, 97'(div_quot), u.sat_val);
  // A zero sample interval gives the largest covariance when the noise is nonzero.
  assign zero_div_val = (rd_a != '0) ? COV_MAX : '0;

  always_comb begin
    case (cnt_q[3:0])
      4'd0:    load_val = val_t'({16'd0, cfg_q[REG_T]});
      4'd1:    load_val = val_t'({16'd0, cfg_q[REG_R]});
      4'd2:    load_val = val_t'({16'd0, cfg_q[REG_QX]});
      4'd3:    load_val = val_t'({16'd0, cfg_q[REG_QY]});
      4'd4:    load_val = val_t'({{16{cfg_q[REG_SP0][31]}}, cfg_q[REG_SP0]});
      4'd5:    load_val = val_t'({{16{cfg_q[REG_SV0][31]}}, cfg_q[REG_SV0]});
      4'd6:    load_val = val_t'({{16{cfg_q[REG_SP1][31]}}, cfg_q[REG_SP1]});
      4'd7:    load_val = val_t'({{16{cfg_q[REG_SV1][31]}}, cfg_q[REG_SV1]});
      4'd8:    load_val = val_t'({{16{mx_q[31]}}, mx_q});
      default: load_val = val_t'({{16{my_q[31]}}, my_q});
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    cnt_d     = cnt_q;
    sing_d    = sing_q;
    we        = 1'b0;
    waddr     = u.d;
    wdata     = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    tt_we     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NSLOT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d   = 6'd0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = load_val;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == S_MY) begin
          pc_d    = cmd_q ? PC_UPD : PC_INIT;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        pc_d    = pc_q + 8'd1;
        state_d = ST_FETCH;
        case (u.op)
          OP_MUL, OP_MULG, OP_MULTT: begin
            mul_start = 1'b1;
            pc_d      = pc_q;
            state_d   = ST_WAIT;
          end
          OP_DIVW: begin
            if (sing_q) begin
              we = 1'b1;
            end else begin
              div_start = 1'b1;
              pc_d      = pc_q;
              state_d   = ST_WAIT;
            end
          end
          OP_DIVOD, OP_DIVDD: begin
            if ((u.op == OP_DIVOD && rd_b == '0) || (u.op == OP_DIVDD && tt_q == '0)) begin
              we    = 1'b1;
              wdata = zero_div_val;
            end else begin
              div_start = 1'b1;
              pc_d      = pc_q;
              state_d   = ST_WAIT;
            end
          end
          OP_ADD: begin
            we    = 1'b1;
            wdata = sadd48(rd_a, rd_b, 1'b0, u.sat_val);
          end
          OP_SUB: begin
            we    = 1'b1;
            wdata = sadd48(rd_a, rd_b, 1'b1, u.sat_val);
          end
          OP_MOV: begin
            we    = 1'b1;
            wdata = rd_a;
          end
          OP_CLR:  we = 1'b1;
          OP_SING: sing_d = (rd_a == '0) || (rd_b == '0);
          OP_GO:   pc_d = PC_COMMON;
          default: begin
            pc_d    = pc_q;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WAIT: begin
        if (mul_done || div_done) begin
          pc_d    = pc_q + 8'd1;
          state_d = ST_FETCH;
          if (u.op == OP_MULTT) begin
            tt_we = 1'b1;
          end else begin
            we    = 1'b1;
            wdata = mul_done ? mul_res : div_res;
          end
        end
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pc_q        <= PC_COMMON;
      cnt_q       <= 6'd0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q[REG_T]   <= 32'd65536;
      cfg_q[REG_R]   <= 32'd65536;
      cfg_q[REG_QX]  <= 32'd65536;
      cfg_q[REG_QY]  <= 32'd65536;
      cfg_q[REG_SP0] <= 32'd0;
      cfg_q[REG_SV0] <= 32'd0;
      cfg_q[REG_SP1] <= 32'd0;
      cfg_q[REG_SV1] <= 32'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      sing_q  <= sing_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      cmd_q <= s_axis_tuser;
      mx_q  <= s_axis_tdata[31:0];
      my_q  <= s_axis_tdata[63:32];
    end
    if (tt_we) tt_q <= mul_prod[63:0];
    // Results are mirrored as they are written, so the output is ready at the end.
    if (we && state_q != ST_LOAD && state_q != ST_CLEAR) begin
      if (waddr == S_E)          est_q[0] <= wdata[31:0];
      if (waddr == S_E + 6'd1)   est_q[1] <= wdata[31:0];
      if (waddr == S_E + 6'd2)   est_q[2] <= wdata[31:0];
      if (waddr == S_E + 6'd3)   est_q[3] <= wdata[31:0];
      if (waddr == S_NU0)        nu_q[0]  <= wdata[31:0];
      if (waddr == S_NU1)        nu_q[1]  <= wdata[31:0];
      if (waddr == S_PS)         pm_q[0]  <= wdata[31:0];
      if (waddr == S_PS + 6'd2)  pm_q[1]  <= wdata[31:0];
    end
    if (load_out) begin
      out_data_q <= {pm_q[1], pm_q[0], nu_q[1], nu_q[0],
                     est_q[3], est_q[2], est_q[1], est_q[0]};
      out_user_q <= sing_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== sv/lkt_chk.sv =====
// Port-level checker for the Kalman tracker, bound to the top level.
module lkt_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A stalled result must stay on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // The block is busy after taking a request and does not take another one at once.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in progress");

  // A new result only appears at the end of work, never from the idle state.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

endmodule

bind linear_kalman_tracker lkt_chk u_lkt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== dv/linear_kalman_tracker_tb.sv =====
// Self-checking testbench of the two-axis Kalman tracker with its own fixed-point predictor.
`timescale 1ns / 100ps

module linear_kalman_tracker_tb;
  import lkt_pkg::*;

  localparam int unsigned FB = 16;
  localparam longint COVM = 64'sh7FFF_FFFF_FFFF;
  localparam longint VALM = 64'sh7FFF_FFFF;
  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;

  // Predicts the tracker result by result and compares what comes out of the block.
  class tracker_scoreboard;
    logic [31:0] regs[8];
    longint pstate[4], cov[16], gain[8], pmeas[2];
    logic [256:0] pending[$];
    int errors, n_init, n_upd, n_sing, n_checked;

    function new();
      regs = '{32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0};
      pstate = '{default: 0};
      cov = '{default: 0};
      gain = '{default: 0};
      pmeas = '{default: 0};
    endfunction

    function longint apply_sign(bit neg, logic [127:0] m, longint mx);
      if (neg) return (m > 128'(mx) + 1) ? -mx - 1 : -longint'(m[63:0]);
      return (m > 128'(mx)) ? mx : longint'(m[63:0]);
    endfunction

    function longint sat_add(longint a, longint b, longint mx);
      longint s;
      s = a + b;
      if (s > mx) return mx;
      if (s < -mx - 1) return -mx - 1;
      return s;
    endfunction

    function logic [127:0] mag(longint v);
      return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    // Exact product, rounded by magnitude so that ties go away from zero.
    function longint fx_mul(longint a, longint b, longint mx);
      logic [127:0] m;
      m = (mag(a) * mag(b) + (128'd1 << (FB - 1))) >> FB;
      return apply_sign((a < 0) != (b < 0), m, mx);
    endfunction

    function logic [127:0] round_quot(logic [127:0] n, logic [127:0] d, int sh);
      logic [127:0] q, rm;
      q = (n << sh) / d;
      rm = (n << sh) % d;
      if (2 * rm >= d) q++;
      return q;
    endfunction

    function longint fx_div(longint n, longint d, longint mx);
      return apply_sign((n < 0) != (d < 0), round_quot(mag(n), mag(d), FB), mx);
    endfunction

    function bit update_covariance();
      longint t, g, qv, a0, a1, m00, m01, w0, w1, t0, t1;
      longint pb[2][4], s[2];
      logic [127:0] tt;
      bit sing;
      int b;
      t = longint'(regs[REG_T]);
      tt = 128'(regs[REG_T]) * 128'(regs[REG_T]);
      g = apply_sign(0, (tt + (128'd1 << FB)) >> (FB + 1), COVM);
      for (int ax = 0; ax < 2; ax++) begin
        b = 2 * ax;
        qv = longint'(ax ? regs[REG_QY] : regs[REG_QX]);
        a0 = fx_mul(g, qv, COVM);
        a1 = fx_mul(t, qv, COVM);
        m00 = sat_add(cov[b*4+b], fx_mul(t, cov[(b+1)*4+b], COVM), COVM);
        m01 = sat_add(cov[b*4+b+1], fx_mul(t, cov[(b+1)*4+b+1], COVM), COVM);
        pb[ax][0] = sat_add(sat_add(m00, fx_mul(m01, t, COVM), COVM),
                            fx_mul(a0, g, COVM), COVM);
        pb[ax][1] = sat_add(m01, fx_mul(a0, t, COVM), COVM);
        pb[ax][2] = sat_add(sat_add(cov[(b+1)*4+b], fx_mul(cov[(b+1)*4+b+1], t, COVM), COVM),
                            fx_mul(a1, g, COVM), COVM);
        pb[ax][3] = sat_add(cov[(b+1)*4+b+1], fx_mul(a1, t, COVM), COVM);
        s[ax] = sat_add(pb[ax][0], longint'(regs[REG_R]), COVM);
      end
      sing = (s[0] == 0) || (s[1] == 0);
      for (int ax = 0; ax < 2; ax++) begin
        b = 2 * ax;
        w0 = sing ? 0 : fx_div(pb[ax][0], s[ax], VALM);
        w1 = sing ? 0 : fx_div(pb[ax][2], s[ax], VALM);
        gain[b*2+ax] = w0;
        gain[(b+1)*2+ax] = w1;
        gain[b*2+1-ax] = 0;
        gain[(b+1)*2+1-ax] = 0;
        t0 = fx_mul(w0, s[ax], COVM);
        t1 = fx_mul(w1, s[ax], COVM);
        cov[b*4+b] = sat_add(pb[ax][0], -fx_mul(t0, w0, COVM), COVM);
        cov[b*4+b+1] = sat_add(pb[ax][1], -fx_mul(t0, w1, COVM), COVM);
        cov[(b+1)*4+b] = sat_add(pb[ax][2], -fx_mul(t1, w0, COVM), COVM);
        cov[(b+1)*4+b+1] = sat_add(pb[ax][3], -fx_mul(t1, w1, COVM), COVM);
      end
      return sing;
    endfunction

    function void note_request(logic cmd, logic [31:0] mx, logic [31:0] my);
      longint est[4], nu[2], r, od, dd, c;
      logic [127:0] tt;
      logic [31:0] mm[2];
      bit sing;
      mm = '{mx, my};
      nu = '{0, 0};
      if (cmd == CMD_INIT) begin
        n_init++;
        r = longint'(regs[REG_R]);
        tt = 128'(regs[REG_T]) * 128'(regs[REG_T]);
        for (int j = 0; j < 4; j++) est[j] = longint'($signed(regs[REG_SP0 + j]));
        if (regs[REG_T] == 0) begin
          od = (r != 0) ? COVM : 0;
          dd = od;
        end else begin
          od = fx_div(r, longint'(regs[REG_T]), COVM);
          dd = apply_sign(0, round_quot(128'(r) * 2, tt, 2 * FB), COVM);
        end
        cov = '{default: 0};
        for (int ax = 0; ax < 2; ax++) begin
          cov[10*ax] = r;
          cov[10*ax+1] = od;
          cov[10*ax+4] = od;
          cov[10*ax+5] = dd;
        end
      end else begin
        n_upd++;
        for (int ax = 0; ax < 2; ax++)
          nu[ax] = sat_add(longint'($signed(mm[ax])), -pmeas[ax], VALM);
        for (int j = 0; j < 4; j++) begin
          c = pstate[j];
          for (int ax = 0; ax < 2; ax++) c = sat_add(c, fx_mul(gain[j*2+ax], nu[ax], VALM), VALM);
          est[j] = c;
        end
      end
      sing = update_covariance();
      if (sing) n_sing++;
      for (int ax = 0; ax < 2; ax++) begin
        pstate[2*ax] = sat_add(est[2*ax], fx_mul(longint'(regs[REG_T]), est[2*ax+1], VALM), VALM);
        pstate[2*ax+1] = est[2*ax+1];
        pmeas[ax] = pstate[2*ax];
      end
      pending.push_back({sing, pmeas[1][31:0], pmeas[0][31:0], nu[1][31:0], nu[0][31:0],
                         est[3][31:0], est[2][31:0], est[1][31:0], est[0][31:0]});
    endfunction

    function void check_result(logic [255:0] data, logic flag);
      string names[9] = '{"est_pos_x", "est_vel_x", "est_pos_y", "est_vel_y", "innov_x",
                          "innov_y", "pred_meas_x", "pred_meas_y", "singular_flag"};
      logic [256:0] want, got;
      got = {flag, data};
      if (pending.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      for (int f = 0; f < 9; f++) begin
        if (want[f*32 +: 32] !== got[f*32 +: 32] && !(f == 8 && want[256] === got[256])) begin
          $error("%s: expected %0h, got %0h", names[f],
                 f == 8 ? 32'(want[256]) : want[f*32 +: 32],
                 f == 8 ? 32'(got[256]) : got[f*32 +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0] s_axis_tdata;     // meas_x, meas_y
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [255:0] m_axis_tdata;    // est_pos_x .. pred_meas_y, 32 bits each
  tracker_scoreboard sb;
  bit hold_req;
  bit calm;
  int unsigned cycles;
  int sent;

  linear_kalman_tracker i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("linear_kalman_tracker_tb: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request from the stimulus.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        if (m_axis_tvalid) sb.check_result(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.regs[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic cmd, logic [31:0] mx, logic [31:0] my);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {my, mx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, mx, my);
    sent++;
  endtask

  // Lets every outstanding result arrive, then a short settling pause.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_pred(longint p, int unsigned spread);
    longint v;
    v = p + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > VALM) v = VALM;
    if (v < -VALM - 1) v = -VALM - 1;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] pick_start(int unsigned spread);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'(int'($urandom_range(0, 2 * spread)) - int'(spread));
  endfunction

  task automatic write_all(logic [31:0] t, logic [31:0] r, logic [31:0] qx, logic [31:0] qy,
                           logic [31:0] p0, logic [31:0] v0, logic [31:0] p1, logic [31:0] v1);
    write_reg(REG_T, t);
    write_reg(REG_R, r);
    write_reg(REG_QX, qx);
    write_reg(REG_QY, qy);
    write_reg(REG_SP0, p0);
    write_reg(REG_SV0, v0);
    write_reg(REG_SP1, p1);
    write_reg(REG_SV1, v1);
    end_writes();
  endtask

  initial begin
    int phase, run_len;
    logic [31:0] t;
    sb = new();
    hold_req = 0;
    calm = 0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_T;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = CMD_INIT;
    s_axis_tdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Update on the reset state before any initialise, then extremes of the measurement.
    send(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
    send(CMD_INIT, 32'h0, 32'h0);
    send(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
    send(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0);
    send(CMD_UPDATE, 32'h0, 32'hFFFF_FFFF);
    drain();
    // Zero interval and zero noise: the innovation covariance is singular.
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF);
    send(CMD_INIT, 32'h0, 32'h0);
    send(CMD_UPDATE, 32'h1234_5678, 32'hFEDC_BA98);
    drain();
    // Zero interval with noise gives the largest off-diagonal covariance.
    write_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'hFFFF_0000,
              32'h0, 32'h0);
    send(CMD_INIT, 32'h0, 32'h0);
    send(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send(CMD_INIT, 32'h0, 32'h0);
    send(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000);
    send(CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_all(32'd1, 32'd1, 32'd0, 32'd1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0);
    send(CMD_INIT, 32'h0, 32'h0);
    send(CMD_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA);
    send(CMD_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    phase = 0;
    while (sent < 1250) begin
      calm = ($urandom_range(0, 3) == 0);
      t = ($urandom_range(0, 9) == 0) ? pick_noise()
                                      : $urandom_range(1 << 12, 1 << 18);
      if (t == 0) t = 32'd1;
      write_all(t, pick_noise(), pick_noise(), pick_noise(), pick_start(1 << 24),
                pick_start(1 << 18), pick_start(1 << 24), pick_start(1 << 18));
      if (phase == 3) hold_req = 1;
      run_len = $urandom_range(10, 50);
      send(CMD_INIT, $urandom(), $urandom());
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(0, 29))
          0: send(CMD_INIT, $urandom(), $urandom());
          1, 2, 3: send(CMD_UPDATE, $urandom(), $urandom());
          default: send(CMD_UPDATE, near_pred(sb.pmeas[0], 1 << 18),
                        near_pred(sb.pmeas[1], 1 << 18));
        endcase
      end
      drain();
      phase++;
    end
    repeat (50) @(posedge clk_i);

    $display("Covered %0d initialise and %0d update requests over %0d register settings;",
             sb.n_init, sb.n_upd, phase + 5);
    $display("%0d results checked, %0d with a singular innovation covariance.",
             sb.n_checked, sb.n_sing);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("linear_kalman_tracker_tb: PASS");
    end else begin
      $display("linear_kalman_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule
